FILE: hw/rtl/pcs_pkg.sv
package pcs_pkg;

	localparam logic [2:0] MODE_INIT    = 3'd0;
	localparam logic [2:0] MODE_IDLE    = 3'd1;
	localparam logic [2:0] MODE_RUNNING = 3'd2;
	localparam logic [2:0] MODE_ERROR   = 3'd3;
	localparam logic [2:0] MODE_WAITING = 3'd4;
	localparam logic [2:0] MODE_HALTED  = 3'd5;

	localparam int unsigned ERR_CANBUS_BIT = 0;
	localparam int unsigned ERR_CHARGE_BIT = 1;

	localparam logic [7:0] ERROR_HALT_LEVEL = 8'd20;
	localparam logic [7:0] COUNT_MAX        = 8'd255;
	localparam logic [1:0] OFF_PULSE_COUNT  = 2'd3;

	localparam logic CFG_PRECHARGE_TICKS  = 1'b0;
	localparam logic CFG_RESET_WAIT_TICKS = 1'b1;

	localparam logic [7:0] PRECHARGE_TICKS_RST  = 8'd10;
	localparam logic [7:0] RESET_WAIT_TICKS_RST = 8'd10;

	typedef struct packed {
		logic [2:0] mode;
		logic       boat_req;
		logic       charging;
		logic       running;
		logic       relay;
		logic [1:0] flags;
		logic [7:0] pre_cnt;
		logic [7:0] rst_cnt;
		logic [7:0] err_cnt;
	} state_t;

	typedef struct packed {
		logic operation;
		logic boat_on_update;
		logic boat_on_value;
		logic set_no_canbus;
		logic set_no_charge;
	} item_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       charge_relay;
		logic       main_on_pulse;
		logic [1:0] main_off_pulses;
		logic       running_flag;
		logic       charging_flag;
		logic [7:0] error_level;
	} result_t;

endpackage

FILE: hw/rtl/pcs_step.sv
module pcs_step (
	input  pcs_pkg::state_t  cur,
	input  pcs_pkg::item_t   item,
	input  logic [7:0]       precharge_ticks,
	input  logic [7:0]       reset_wait_ticks,
	output pcs_pkg::state_t  nxt,
	output pcs_pkg::result_t res
);

	always_comb begin
		pcs_pkg::state_t n;
		logic            on_pulse;
		logic [1:0]      off_pulses;
		logic            wait_run;

		n          = cur;
		on_pulse   = 1'b0;
		off_pulses = 2'd0;
		wait_run   = 1'b0;

		// Halted and the unused codes above it freeze the whole state.
		if (cur.mode < pcs_pkg::MODE_HALTED) begin
			if (item.boat_on_update) begin
				n.boat_req = item.boat_on_value;
			end
			if (item.set_no_canbus) begin
				n.flags[pcs_pkg::ERR_CANBUS_BIT] = 1'b1;
			end
			if (item.set_no_charge) begin
				n.flags[pcs_pkg::ERR_CHARGE_BIT] = 1'b1;
			end

			if (item.operation) begin
				if (n.flags != 2'd0) begin
					n.mode = n.flags[pcs_pkg::ERR_CHARGE_BIT] ?
						pcs_pkg::MODE_WAITING : pcs_pkg::MODE_ERROR;
				end

				unique case (n.mode)
					pcs_pkg::MODE_INIT: begin
						n.boat_req = 1'b0;
						n.relay    = 1'b0;
						off_pulses = pcs_pkg::OFF_PULSE_COUNT;
						n.flags    = 2'd0;
						n.pre_cnt  = 8'd0;
						n.mode     = pcs_pkg::MODE_IDLE;
					end
					pcs_pkg::MODE_IDLE: begin
						n.running = 1'b0;
						if (n.boat_req) begin
							n.relay    = 1'b1;
							n.charging = 1'b1;
							if (n.pre_cnt <= precharge_ticks) begin
								if (n.pre_cnt != pcs_pkg::COUNT_MAX) begin
									n.pre_cnt = n.pre_cnt + 8'd1;
								end
							end else begin
								on_pulse   = 1'b1;
								n.relay    = 1'b0;
								n.charging = 1'b0;
								n.pre_cnt  = 8'd0;
								n.mode     = pcs_pkg::MODE_RUNNING;
							end
						end else if (n.charging) begin
							n.relay    = 1'b0;
							n.charging = 1'b0;
							n.pre_cnt  = 8'd0;
							n.mode     = pcs_pkg::MODE_RUNNING;
						end
					end
					pcs_pkg::MODE_RUNNING: begin
						n.running = 1'b1;
						if (!n.boat_req) begin
							n.relay    = 1'b0;
							off_pulses = pcs_pkg::OFF_PULSE_COUNT;
							n.pre_cnt  = 8'd0;
							n.mode     = pcs_pkg::MODE_IDLE;
						end
					end
					pcs_pkg::MODE_ERROR: begin
						n.mode = pcs_pkg::MODE_INIT;
						if (n.err_cnt != pcs_pkg::COUNT_MAX) begin
							n.err_cnt = n.err_cnt + 8'd1;
						end
						if (n.err_cnt >= pcs_pkg::ERROR_HALT_LEVEL) begin
							n.mode = pcs_pkg::MODE_HALTED;
							n.flags[pcs_pkg::ERR_CHARGE_BIT] = 1'b0;
						end
						if (n.flags[pcs_pkg::ERR_CHARGE_BIT]) begin
							n.mode = pcs_pkg::MODE_WAITING;
						end
						// The wait-reset step follows the error handler in every case.
						wait_run = 1'b1;
					end
					default: begin
						wait_run = 1'b1;
					end
				endcase

				if (wait_run && !n.boat_req) begin
					if (n.rst_cnt < reset_wait_ticks) begin
						n.rst_cnt = n.rst_cnt + 8'd1;
					end else begin
						n.mode = pcs_pkg::MODE_HALTED;
						n.flags[pcs_pkg::ERR_CHARGE_BIT] = 1'b0;
					end
				end
			end
		end

		nxt                 = n;
		res.mode            = n.mode;
		res.charge_relay    = n.relay;
		res.main_on_pulse   = on_pulse;
		res.main_off_pulses = off_pulses;
		res.running_flag    = n.running;
		res.charging_flag   = n.charging;
		res.error_level     = n.err_cnt;
	end

endmodule

FILE: hw/rtl/precharge_contactor_sequencer.sv
// Precharge and main contactor sequencer.
// Input items arrive on s_tvalid/s_tready with s_tuser = operation (1 = machine
// tick, 0 = request and error flag updates only) and the update fields in s_tdata.
// Every accepted item yields exactly one result item on m_tvalid/m_tready: the
// mode, the relay level, the pulse requests, the status flags and the error level.
// An accepted item is held in an input register; the mode logic evaluates it
// against the stored state and loads the result register once that register is
// free, that is when no result is waiting or the receiver takes it.
// The input register and the result register form two stages, so one item per
// cycle is sustained while m_tready stays high; the step logic is combinational.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that s_tready drops until the result is taken.
// Configuration (cfg_we, cfg_index, cfg_data) writes the precharge hold length
// (index 0) and the reset wait length (index 1), and is meant for idle periods.
// Reset puts the machine in the initializing mode with all counters, flags and
// requests cleared, both registers back to 10, and no item in flight.
module precharge_contactor_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] boat_on_update, [1] boat_on_value, [2] set_no_canbus, [3] set_no_charge
	input  logic [7:0]  s_tdata,
	// [0] operation
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] mode, [3] charge_relay, [4] main_on_pulse, [6:5] main_off_pulses,
	// [7] running_flag, [8] charging_flag, [16:9] error_level
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0]       precharge_ticks_q;
	logic [7:0]       reset_wait_ticks_q;
	pcs_pkg::state_t  state_q;
	pcs_pkg::state_t  state_nxt;
	pcs_pkg::item_t   item_s1;
	logic             valid_s1;
	pcs_pkg::result_t res_nxt;
	pcs_pkg::result_t res_q;
	logic             advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precharge_ticks_q  <= pcs_pkg::PRECHARGE_TICKS_RST;
			reset_wait_ticks_q <= pcs_pkg::RESET_WAIT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcs_pkg::CFG_PRECHARGE_TICKS:  precharge_ticks_q  <= cfg_data;
				pcs_pkg::CFG_RESET_WAIT_TICKS: reset_wait_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation      <= s_tuser;
			item_s1.boat_on_update <= s_tdata[0];
			item_s1.boat_on_value  <= s_tdata[1];
			item_s1.set_no_canbus  <= s_tdata[2];
			item_s1.set_no_charge  <= s_tdata[3];
		end
	end

	pcs_step u_step (
		.cur              (state_q),
		.item             (item_s1),
		.precharge_ticks  (precharge_ticks_q),
		.reset_wait_ticks (reset_wait_ticks_q),
		.nxt              (state_nxt),
		.res              (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: pcs_pkg::MODE_INIT, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign m_tdata = {7'd0, res_q.error_level, res_q.charging_flag, res_q.running_flag,
		res_q.main_off_pulses, res_q.main_on_pulse, res_q.charge_relay, res_q.mode};

	// Once halted, nothing but reset may change the machine state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == pcs_pkg::MODE_HALTED) |=> (state_q == $past(state_q)))
		else $error("state changed while halted");

	// A close request and open requests never come out of the same step.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.main_on_pulse && (res_q.main_off_pulses != 2'd0)))
		else $error("main contactor asked to close and open in one step");

	// The error level only ever counts up between resets.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (state_q.err_cnt >= $past(state_q.err_cnt)))
		else $error("error count decreased");

endmodule
